// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds -> expr holds in the same cycle
`define LPG_ASSERT_IMP(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// cond holds -> expr holds in the next cycle
`define LPG_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/lpg_pkg.sv -----
`timescale 1ns / 1ps

package lpg_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int PHASE_BITS       = 32;
   localparam int COORD_BITS       = 8;

   localparam int TBL_ENTRIES = SINE_TABLE_DEPTH + 1;
   localparam int TBL_AW      = $clog2(TBL_ENTRIES);
   localparam int TBL_DW      = 16;
   localparam int QSHIFT      = PHASE_BITS - 2;

   localparam int FREQ_W = 7;
   localparam int OFS_W  = 16;
   localparam int STEP_W = 32;
   localparam int NPTS_W = 16;
   localparam int SPAN_W = 8;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;

   localparam int MUL_W = (PHASE_BITS > FREQ_W + STEP_W + 1) ? PHASE_BITS
                                                              : FREQ_W + STEP_W + 1;
   localparam int CMP_W = (COORD_BITS + 1 > 10) ? COORD_BITS + 1 : 10;
   localparam logic [CMP_W-1:0] COORD_MAX = CMP_W'((1 << COORD_BITS) - 1);

   localparam logic [TBL_DW:0] SINE_MID  = (TBL_DW + 1)'(32768);
   localparam logic [17:0]     SINE_PEAK = 18'(32768);

   // quarter-wave polynomial, Q30
   localparam int POLY_W = 31;
   localparam logic [POLY_W-1:0] POLY_C0 = POLY_W'(172272);
   localparam logic [POLY_W-1:0] POLY_C1 = POLY_W'(5026995);
   localparam logic [POLY_W-1:0] POLY_C2 = POLY_W'(85569306);
   localparam logic [POLY_W-1:0] POLY_C3 = POLY_W'(693598668);
   localparam logic [POLY_W-1:0] POLY_C4 = POLY_W'(1686629713);
   localparam logic [POLY_W-1:0] U_STEP  = POLY_W'((64'd1 << 30) / SINE_TABLE_DEPTH);
   localparam logic [TBL_AW-1:0] U_REM   = TBL_AW'((64'd1 << 30) % SINE_TABLE_DEPTH);

   localparam logic [FREQ_W-1:0] RST_FREQ_A       = FREQ_W'(2);
   localparam logic [FREQ_W-1:0] RST_FREQ_B       = FREQ_W'(3);
   localparam logic [OFS_W-1:0]  RST_PHASE_OFFSET = OFS_W'(0);
   localparam logic [STEP_W-1:0] RST_BASE_STEP    = STEP_W'(65536);
   localparam logic [NPTS_W-1:0] RST_NUM_POINTS   = NPTS_W'(65535);
   localparam logic [SPAN_W-1:0] RST_SCREEN_ROWS  = SPAN_W'(24);
   localparam logic [SPAN_W-1:0] RST_SCREEN_COLS  = SPAN_W'(80);

   typedef enum logic [CSR_IW-1:0] {
      CSR_FREQ_A       = 3'd0,
      CSR_FREQ_B       = 3'd1,
      CSR_PHASE_OFFSET = 3'd2,
      CSR_BASE_STEP    = 3'd3,
      CSR_NUM_POINTS   = 3'd4,
      CSR_SCREEN_ROWS  = 3'd5,
      CSR_SCREEN_COLS  = 3'd6
   } csr_idx_type;

   typedef logic [PHASE_BITS-1:0] phase_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [TBL_DW-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      phase_type         x_inc;
      phase_type         y_inc;
      logic [OFS_W-1:0]  phase_offset;
      logic [NPTS_W-1:0] num_points;
   } phase_cfg_type;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic last;
   } pt_ctl_type;

   function automatic phase_type phase_inc(logic [FREQ_W-1:0] freq, logic [STEP_W-1:0] step);
      logic signed [MUL_W-1:0] prod;
      prod = MUL_W'(signed'(freq)) * MUL_W'(signed'({1'b0, step}));
      return prod[PHASE_BITS-1:0];
   endfunction

endpackage

// ----- rtl/lpg_ram.sv -----
`timescale 1ns / 1ps

module lpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/lpg_table_fill.sv -----
`timescale 1ns / 1ps

module lpg_table_fill (
   input  logic               clock,
   input  logic               reset,
   output lpg_pkg::tbl_wr_type wr,
   output logic               done
);
   import lpg_pkg::*;

   typedef enum logic [2:0] {
      ST_SQUARE,
      ST_HORNER1,
      ST_HORNER2,
      ST_HORNER3,
      ST_HORNER4,
      ST_ROUND,
      ST_DONE
   } fill_state_type;

   fill_state_type     state_ff;
   logic [TBL_AW-1:0]  index_ff;
   logic [POLY_W-1:0]  u_ff;
   logic [TBL_AW-1:0]  u_rem_ff;
   logic [POLY_W-1:0]  u2_ff;
   logic [POLY_W-1:0]  acc_ff;
   tbl_wr_type         wr_ff;

   logic [POLY_W-1:0]   op_a;
   logic [POLY_W-1:0]   op_b;
   logic [2*POLY_W-1:0] prod;
   logic [31:0]         prod_sh;
   logic [32:0]         round_sum;
   logic [17:0]         rounded;
   logic [TBL_DW-1:0]   sample;
   logic [TBL_AW:0]     u_rem_sum;
   logic                u_wrap;

   always_comb begin
      op_a = u2_ff;
      op_b = acc_ff;
      case (state_ff)
         ST_SQUARE: begin
            op_a = u_ff;
            op_b = u_ff;
         end
         ST_HORNER1: begin
            op_b = POLY_C0;
         end
         ST_ROUND: begin
            op_a = u_ff;
         end
         default: begin
            op_a = u2_ff;
            op_b = acc_ff;
         end
      endcase
      prod      = (2 * POLY_W)'(op_a) * (2 * POLY_W)'(op_b);
      prod_sh   = prod[2*POLY_W-1:30];
      round_sum = {1'b0, prod_sh} + 33'(16384);
      rounded   = round_sum[32:15];
      sample    = (rounded > SINE_PEAK) ? TBL_DW'(32768) : rounded[TBL_DW-1:0];
      u_rem_sum = {1'b0, u_rem_ff} + {1'b0, U_REM};
      u_wrap    = u_rem_sum >= (TBL_AW + 1)'(SINE_TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SQUARE;
         index_ff <= '0;
         u_ff     <= '0;
         u_rem_ff <= '0;
         wr_ff.en <= 1'b0;
      end else begin
         wr_ff.en <= 1'b0;
         case (state_ff)
            ST_SQUARE: begin
               u2_ff    <= prod_sh[POLY_W-1:0];
               state_ff <= ST_HORNER1;
            end
            ST_HORNER1: begin
               acc_ff   <= POLY_W'({1'b0, POLY_C1} - prod_sh);
               state_ff <= ST_HORNER2;
            end
            ST_HORNER2: begin
               acc_ff   <= POLY_W'({1'b0, POLY_C2} - prod_sh);
               state_ff <= ST_HORNER3;
            end
            ST_HORNER3: begin
               acc_ff   <= POLY_W'({1'b0, POLY_C3} - prod_sh);
               state_ff <= ST_HORNER4;
            end
            ST_HORNER4: begin
               acc_ff   <= POLY_W'({1'b0, POLY_C4} - prod_sh);
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               wr_ff.en   <= 1'b1;
               wr_ff.addr <= index_ff;
               wr_ff.data <= sample;
               index_ff   <= index_ff + 1'b1;
               u_ff       <= u_ff + U_STEP + POLY_W'(u_wrap);
               u_rem_ff   <= u_wrap ? TBL_AW'(u_rem_sum - (TBL_AW + 1)'(SINE_TABLE_DEPTH))
                                    : u_rem_sum[TBL_AW-1:0];
               if (index_ff == TBL_AW'(SINE_TABLE_DEPTH)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_DONE: begin
               state_ff <= ST_DONE;
            end
            default: begin
               state_ff <= ST_SQUARE;
            end
         endcase
      end
   end

   assign wr   = wr_ff;
   assign done = (state_ff == ST_DONE) && !wr_ff.en;

endmodule

// ----- rtl/lpg_phase.sv -----
`timescale 1ns / 1ps

module lpg_phase (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         start_req,
   input  lpg_pkg::phase_cfg_type       cfg,
   output logic [lpg_pkg::TBL_AW-1:0]   x_addr,
   output logic [lpg_pkg::TBL_AW-1:0]   y_addr,
   output lpg_pkg::pt_ctl_type          ctl
);
   import lpg_pkg::*;

   localparam int KPROD_W = QSHIFT + TBL_AW;

   phase_type         x_phase_ff;
   phase_type         x_phase_in;
   phase_type         y_phase_ff;
   phase_type         y_phase_in;
   phase_type         x_cur;
   phase_type         y_cur;
   phase_type         x_look;
   logic [NPTS_W-1:0] index_ff;
   logic [NPTS_W-1:0] index_in;
   logic [NPTS_W-1:0] index_cur;
   logic              last;

   // quadrant folding onto the quarter-wave table
   function automatic logic [TBL_AW-1:0] tbl_addr(phase_type p);
      logic [KPROD_W-1:0] kprod;
      logic [TBL_AW-1:0]  k;
      kprod = KPROD_W'(p[QSHIFT-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);
      k     = kprod[QSHIFT +: TBL_AW];
      return p[QSHIFT] ? TBL_AW'(SINE_TABLE_DEPTH) - k : k;
   endfunction

   always_comb begin
      x_cur     = start_req ? '0 : x_phase_ff;
      y_cur     = start_req ? '0 : y_phase_ff;
      index_cur = start_req ? '0 : index_ff;
      x_look    = x_cur + (PHASE_BITS'(cfg.phase_offset) << (PHASE_BITS - OFS_W));
      last      = index_cur >= cfg.num_points;

      x_addr    = tbl_addr(x_look);
      y_addr    = tbl_addr(y_cur);
      ctl.x_neg = x_look[PHASE_BITS-1];
      ctl.y_neg = y_cur[PHASE_BITS-1];
      ctl.last  = last;

      x_phase_in = x_phase_ff;
      y_phase_in = y_phase_ff;
      index_in   = index_ff;
      if (advance) begin
         if (last) begin
            x_phase_in = '0;
            y_phase_in = '0;
            index_in   = '0;
         end else begin
            x_phase_in = x_cur + cfg.x_inc;
            y_phase_in = y_cur + cfg.y_inc;
            index_in   = index_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_phase_ff <= '0;
         y_phase_ff <= '0;
         index_ff   <= '0;
      end else begin
         x_phase_ff <= x_phase_in;
         y_phase_ff <= y_phase_in;
         index_ff   <= index_in;
      end
   end

endmodule

// ----- rtl/lpg_scale.sv -----
`timescale 1ns / 1ps

module lpg_scale (
   input  logic [lpg_pkg::TBL_DW-1:0]     sample,
   input  logic                           neg,
   input  logic [lpg_pkg::SPAN_W-1:0]     span,
   input  logic                           bias,
   output logic [lpg_pkg::COORD_BITS-1:0] coord
);
   import lpg_pkg::*;

   localparam int PROD_W = SPAN_W + TBL_DW + 1;

   logic [TBL_DW:0]   offset;
   logic [PROD_W-1:0] prod;
   logic [SPAN_W:0]   scaled;
   logic [CMP_W-1:0]  sum;

   always_comb begin
      offset = neg ? SINE_MID - {1'b0, sample} : SINE_MID + {1'b0, sample};
      prod   = PROD_W'(span) * PROD_W'(offset);
      scaled = prod[TBL_DW +: SPAN_W + 1];
      sum    = CMP_W'(scaled) + CMP_W'(bias);
      coord  = (sum > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : sum[COORD_BITS-1:0];
   end

endmodule

// ----- rtl/lissajous_point_generator.sv -----
// Lissajous point generator: each request yields one point (x, y, last) of the
// curve x = sin(a*t + delta), y = sin(b*t), with start_req restarting the sweep at
// t = 0. After reset the quarter-wave sine table (SINE_TABLE_DEPTH + 1 entries) is
// computed into its RAM by a shared-multiplier polynomial sequencer, and req_ready
// stays low until that fill is done. From then on one request is taken every clock
// unless the response side stalls; the phase accumulators advance by one add per
// point and the two sine lookups share one dual-read table RAM, so each point passes
// the RAM read register and then the output register.
// Configuration writes are taken at any time and must be made while the block is
// idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lissajous_point_generator (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpg_pkg::CSR_IW-1:0]     csr_index,
   input  logic [lpg_pkg::CSR_DW-1:0]     csr_wdata,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_start_req,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpg_pkg::COORD_BITS-1:0] rsp_x_pos,
   output logic [lpg_pkg::COORD_BITS-1:0] rsp_y_pos,
   output logic                           rsp_last
);
   import lpg_pkg::*;

   logic [FREQ_W-1:0] freq_a_ff;
   logic [FREQ_W-1:0] freq_b_ff;
   logic [OFS_W-1:0]  phase_offset_ff;
   logic [STEP_W-1:0] base_step_ff;
   logic [NPTS_W-1:0] num_points_ff;
   logic [SPAN_W-1:0] screen_rows_ff;
   logic [SPAN_W-1:0] screen_cols_ff;
   phase_type         x_inc_ff;
   phase_type         x_inc_in;
   phase_type         y_inc_ff;
   phase_type         y_inc_in;

   logic              wr_freq_a;
   logic              wr_freq_b;
   logic              wr_base_step;
   logic [STEP_W-1:0] step_sel;
   logic [SPAN_W-1:0] y_span;

   tbl_wr_type        tbl_wr;
   logic              fill_done;
   phase_cfg_type     phase_cfg;
   logic [TBL_AW-1:0] x_addr;
   logic [TBL_AW-1:0] y_addr;
   pt_ctl_type        ctl;
   logic [TBL_DW-1:0] x_sample;
   logic [TBL_DW-1:0] y_sample;

   logic              en_out;
   logic              en_s1;
   logic              req_accept;
   logic              s1_valid_ff;
   pt_ctl_type        s1_ctl_ff;
   logic [COORD_BITS-1:0] x_coord;
   logic [COORD_BITS-1:0] y_coord;
   logic              rsp_valid_ff;
   logic [COORD_BITS-1:0] rsp_x_pos_ff;
   logic [COORD_BITS-1:0] rsp_y_pos_ff;
   logic              rsp_last_ff;

   // configuration registers
   assign csr_ready    = 1'b1;
   assign wr_freq_a    = csr_valid && (csr_index == CSR_FREQ_A);
   assign wr_freq_b    = csr_valid && (csr_index == CSR_FREQ_B);
   assign wr_base_step = csr_valid && (csr_index == CSR_BASE_STEP);

   always_comb begin
      step_sel = wr_base_step ? csr_wdata[STEP_W-1:0] : base_step_ff;
      x_inc_in = phase_inc(wr_freq_a ? csr_wdata[FREQ_W-1:0] : freq_a_ff, step_sel);
      y_inc_in = phase_inc(wr_freq_b ? csr_wdata[FREQ_W-1:0] : freq_b_ff, step_sel);
      y_span   = (screen_rows_ff == '0) ? '0 : screen_rows_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_a_ff       <= RST_FREQ_A;
         freq_b_ff       <= RST_FREQ_B;
         phase_offset_ff <= RST_PHASE_OFFSET;
         base_step_ff    <= RST_BASE_STEP;
         num_points_ff   <= RST_NUM_POINTS;
         screen_rows_ff  <= RST_SCREEN_ROWS;
         screen_cols_ff  <= RST_SCREEN_COLS;
         x_inc_ff        <= phase_inc(RST_FREQ_A, RST_BASE_STEP);
         y_inc_ff        <= phase_inc(RST_FREQ_B, RST_BASE_STEP);
      end else if (csr_valid) begin
         x_inc_ff <= x_inc_in;
         y_inc_ff <= y_inc_in;
         case (csr_idx_type'(csr_index))
            CSR_FREQ_A:       freq_a_ff       <= csr_wdata[FREQ_W-1:0];
            CSR_FREQ_B:       freq_b_ff       <= csr_wdata[FREQ_W-1:0];
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_wdata[OFS_W-1:0];
            CSR_BASE_STEP:    base_step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_NUM_POINTS:   num_points_ff   <= csr_wdata[NPTS_W-1:0];
            CSR_SCREEN_ROWS:  screen_rows_ff  <= csr_wdata[SPAN_W-1:0];
            CSR_SCREEN_COLS:  screen_cols_ff  <= csr_wdata[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign phase_cfg.x_inc        = x_inc_ff;
   assign phase_cfg.y_inc        = y_inc_ff;
   assign phase_cfg.phase_offset = phase_offset_ff;
   assign phase_cfg.num_points   = num_points_ff;

   // pipeline control
   assign en_out     = !rsp_valid_ff || rsp_ready;
   assign en_s1      = !s1_valid_ff || en_out;
   assign req_ready  = fill_done && en_s1;
   assign req_accept = req_valid && req_ready;

   lpg_table_fill u_fill (
      .clock (clock),
      .reset (reset),
      .wr    (tbl_wr),
      .done  (fill_done)
   );

   lpg_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_accept),
      .start_req (req_start_req),
      .cfg       (phase_cfg),
      .x_addr    (x_addr),
      .y_addr    (y_addr),
      .ctl       (ctl)
   );

   lpg_ram #(
      .WIDTH (TBL_DW),
      .DEPTH (TBL_ENTRIES)
   ) u_sine_ram (
      .clock     (clock),
      .wr_en     (tbl_wr.en),
      .wr_addr   (tbl_wr.addr),
      .wr_data   (tbl_wr.data),
      .rd_en     (en_s1),
      .rd_addr_a (x_addr),
      .rd_data_a (x_sample),
      .rd_addr_b (y_addr),
      .rd_data_b (y_sample)
   );

   lpg_scale u_scale_x (
      .sample (x_sample),
      .neg    (s1_ctl_ff.x_neg),
      .span   (screen_cols_ff),
      .bias   (1'b0),
      .coord  (x_coord)
   );

   lpg_scale u_scale_y (
      .sample (y_sample),
      .neg    (s1_ctl_ff.y_neg),
      .span   (y_span),
      .bias   (1'b1),
      .coord  (y_coord)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_s1) begin
            s1_valid_ff <= req_accept;
         end
         if (en_out) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_ctl_ff <= ctl;
      end
      if (en_out) begin
         rsp_x_pos_ff <= x_coord;
         rsp_y_pos_ff <= y_coord;
         rsp_last_ff  <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_pos = rsp_x_pos_ff;
   assign rsp_y_pos = rsp_y_pos_ff;
   assign rsp_last  = rsp_last_ff;

   `LPG_ASSERT_NEXT(a_fill_stays_done, fill_done, fill_done, "sine table fill done dropped")
   `LPG_ASSERT_IMP(a_no_write_in_flight, tbl_wr.en, !s1_valid_ff && !rsp_valid_ff, "table write with a request in flight")
   `LPG_ASSERT_IMP(a_row_from_one, rsp_valid, rsp_y_pos != '0, "row coordinate below one")

endmodule

// ----- sim/tb_lissajous_point_generator.sv -----
`timescale 1ns / 1ps

module tb_lissajous_point_generator;
   import lpg_pkg::*;

   localparam int LIMIT_CYCLES    = 200000;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int HOLD_AFTER      = 120;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 4;
   localparam int END_CYCLES      = 8;
   localparam int D               = SINE_TABLE_DEPTH;
   localparam int CMAX            = (1 << COORD_BITS) - 1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } point_type;

   typedef enum logic {ROW_CFG, ROW_REQ} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_idx_type           idx;
      logic [CSR_DW-1:0]     data;
      logic                  start;
      logic                  typed;
      logic [COORD_BITS-1:0] want_x;
      logic [COORD_BITS-1:0] want_y;
      logic                  want_last;
   } dir_row_type;

   localparam int N_DIR = 31;
   localparam dir_row_type DIRECTED [N_DIR] = '{
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b1, 8'd40,  8'd12,  1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b1, 1'b1, 8'd40,  8'd12,  1'b0},
      '{ROW_CFG, CSR_NUM_POINTS,   32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b1, 8'd40,  8'd12,  1'b1},
      '{ROW_CFG, CSR_SCREEN_ROWS,  32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_SCREEN_COLS,  32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b1, 8'd0,   8'd1,   1'b1},
      '{ROW_CFG, CSR_FREQ_A,       32'hFFFF_FFE0,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_FREQ_B,       32'd32,         1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_PHASE_OFFSET, 32'h0000_FFFF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_BASE_STEP,    32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_NUM_POINTS,   32'd3,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_SCREEN_ROWS,  32'd255,        1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_SCREEN_COLS,  32'd255,        1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_PHASE_OFFSET, 32'd16384,      1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b1, 1'b1, 8'd255, 8'd128, 1'b0},
      '{ROW_CFG, CSR_PHASE_OFFSET, 32'd49152,      1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b1, 1'b1, 8'd0,   8'd128, 1'b0},
      '{ROW_CFG, CSR_BASE_STEP,    32'd1,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_FREQ_A,       32'd1,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_FREQ_B,       32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_CFG, CSR_NUM_POINTS,   32'd65535,      1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
      '{ROW_REQ, CSR_FREQ_A,       32'd0,          1'b0, 1'b0, 8'd0,   8'd0,   1'b0}
   };

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index     = CSR_FREQ_A;
   logic [CSR_DW-1:0]     csr_wdata     = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [COORD_BITS-1:0] rsp_x_pos;
   logic [COORD_BITS-1:0] rsp_y_pos;
   logic                  rsp_last;

   // predictor copy of settings and sweep state
   logic signed [FREQ_W-1:0] cfg_freq_a = 7'sd2;
   logic signed [FREQ_W-1:0] cfg_freq_b = 7'sd3;
   logic [OFS_W-1:0]         cfg_offset = 16'd0;
   logic [STEP_W-1:0]        cfg_step   = 32'd65536;
   logic [NPTS_W-1:0]        cfg_npts   = 16'd65535;
   logic [SPAN_W-1:0]        cfg_rows   = 8'd24;
   logic [SPAN_W-1:0]        cfg_cols   = 8'd80;
   phase_type                sweep_x    = '0;
   phase_type                sweep_y    = '0;
   logic [NPTS_W-1:0]        sweep_idx  = '0;
   int                       quarter_sine [D+1];

   point_type expected_points [$];
   int     error_count  = 0;
   int     points_seen  = 0;
   int     hold_cycles  = 0;
   int     cycle_count  = 0;
   bit     quiet_run    = 1'b0;

   lissajous_point_generator i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_pos     (rsp_x_pos),
      .rsp_y_pos     (rsp_y_pos),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // quarter-wave table, Q30 odd polynomial
   initial begin
      longint unsigned u, u2, acc, s;
      for (int i = 0; i <= D; i++) begin
         u   = (longint'(i) << 30) / D;
         u2  = (u * u) >> 30;
         acc = 172272;
         acc = 5026995 - ((u2 * acc) >> 30);
         acc = 85569306 - ((u2 * acc) >> 30);
         acc = 693598668 - ((u2 * acc) >> 30);
         acc = 1686629713 - ((u2 * acc) >> 30);
         s   = (u * acc) >> 30;
         s   = (s + 16384) >> 15;
         if (s > 32768) begin
            s = 32768;
         end
         quarter_sine[i] = int'(s);
      end
   end

   function automatic int sine_at(phase_type ph);
      longint k;
      int     v;
      k = (longint'(ph[QSHIFT-1:0]) * D) >> QSHIFT;
      if (k > D) begin
         k = D;
      end
      v = ph[QSHIFT] ? quarter_sine[D - int'(k)] : quarter_sine[int'(k)];
      return ph[QSHIFT+1] ? -v : v;
   endfunction

   function automatic point_type predict_point(logic start);
      point_type pt;
      phase_type x_look;
      int        sx, sy;
      longint    xc, yc, yspan;
      if (start) begin
         sweep_x   = '0;
         sweep_y   = '0;
         sweep_idx = '0;
      end
      x_look = sweep_x + {cfg_offset, {(PHASE_BITS-16){1'b0}}};
      sx     = sine_at(x_look);
      sy     = sine_at(sweep_y);
      yspan  = (cfg_rows != 0) ? longint'(cfg_rows) - 1 : 0;
      xc     = (longint'(cfg_cols) * longint'(sx + 32768)) >> 16;
      yc     = ((yspan * longint'(sy + 32768)) >> 16) + 1;
      if (xc > CMAX) begin
         xc = CMAX;
      end
      if (yc > CMAX) begin
         yc = CMAX;
      end
      pt.x    = xc[COORD_BITS-1:0];
      pt.y    = yc[COORD_BITS-1:0];
      pt.last = (sweep_idx >= cfg_npts);
      if (pt.last) begin
         sweep_x   = '0;
         sweep_y   = '0;
         sweep_idx = '0;
      end else begin
         sweep_x   = sweep_x + PHASE_BITS'(longint'(cfg_freq_a) * longint'(cfg_step));
         sweep_y   = sweep_y + PHASE_BITS'(longint'(cfg_freq_b) * longint'(cfg_step));
         sweep_idx = sweep_idx + 1'b1;
      end
      return pt;
   endfunction

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FREQ_A:       cfg_freq_a = data[FREQ_W-1:0];
         CSR_FREQ_B:       cfg_freq_b = data[FREQ_W-1:0];
         CSR_PHASE_OFFSET: cfg_offset = data[OFS_W-1:0];
         CSR_BASE_STEP:    cfg_step   = data[STEP_W-1:0];
         CSR_NUM_POINTS:   cfg_npts   = data[NPTS_W-1:0];
         CSR_SCREEN_ROWS:  cfg_rows   = data[SPAN_W-1:0];
         CSR_SCREEN_COLS:  cfg_cols   = data[SPAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_point(input logic start, input logic typed, input point_type typed_pt);
      point_type pt;
      if (!quiet_run && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
      pt = predict_point(start);
      expected_points.push_back(typed ? typed_pt : pt);
   endtask

   task automatic drain_points(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // response side: check, then decide ready for the next cycle
   always @(posedge clock) begin : rsp_side
      point_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected point x=%0d y=%0d last=%0d",
                           rsp_x_pos, rsp_y_pos, rsp_last);
               end
            end else begin
               want = expected_points.pop_front();
               if (rsp_x_pos !== want.x || rsp_y_pos !== want.y || rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("point mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                              want.x, want.y, want.last, rsp_x_pos, rsp_y_pos, rsp_last);
                  end
               end
            end
            if (points_seen == HOLD_AFTER) begin
               hold_cycles = LONG_HOLD;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
            hold_cycles = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int              fa, fb;
      logic [15:0]     ofs, npts;
      logic [31:0]     step;
      logic [7:0]      rows, cols;
      point_type       typed_pt;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIR; r++) begin
         if (DIRECTED[r].kind == ROW_CFG) begin
            if (r == 0 || DIRECTED[r-1].kind != ROW_CFG) begin
               drain_points(SETTLE_CYCLES);
            end
            write_csr(DIRECTED[r].idx, DIRECTED[r].data);
            if (r == N_DIR - 1 || DIRECTED[r+1].kind != ROW_CFG) begin
               csr_valid <= 1'b0;
            end
         end else begin
            typed_pt.x    = DIRECTED[r].want_x;
            typed_pt.y    = DIRECTED[r].want_y;
            typed_pt.last = DIRECTED[r].want_last;
            send_point(DIRECTED[r].start, DIRECTED[r].typed, typed_pt);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         drain_points(SETTLE_CYCLES);
         case (p)
            0: begin
               fa = 32;  fb = -32; ofs = 16'hFFFF; step = 32'hFFFF_FFFF;
               npts = 16'($urandom_range(1, 12)); rows = 8'd255; cols = 8'd255;
            end
            1: begin
               fa = -32; fb = 32;  ofs = 16'h0000; step = 32'd1;
               npts = 16'd1; rows = 8'd1; cols = 8'd1;
            end
            default: begin
               fa   = int'($urandom_range(0, 64)) - 32;
               fb   = int'($urandom_range(0, 64)) - 32;
               ofs  = 16'($urandom);
               step = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 1 << 20)) : $urandom;
               if (step == 0) begin
                  step = 32'd1;
               end
               npts = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
               rows = 8'($urandom_range(0, 255));
               cols = 8'($urandom_range(0, 255));
            end
         endcase
         write_csr(CSR_FREQ_A, 32'(fa));
         write_csr(CSR_FREQ_B, 32'(fb));
         write_csr(CSR_PHASE_OFFSET, 32'(ofs));
         write_csr(CSR_BASE_STEP, step);
         write_csr(CSR_NUM_POINTS, 32'(npts));
         write_csr(CSR_SCREEN_ROWS, 32'(rows));
         write_csr(CSR_SCREEN_COLS, 32'(cols));
         csr_valid <= 1'b0;
         quiet_run = (p == N_PHASES - 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 3 && i == 25) begin
               drain_points(0);
            end
            send_point($urandom_range(0, 15) == 0, 1'b0, typed_pt);
         end
      end

      drain_points(END_CYCLES);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_ram.sv
rtl/lpg_table_fill.sv
rtl/lpg_phase.sv
rtl/lpg_scale.sv
rtl/lissajous_point_generator.sv
sim/tb_lissajous_point_generator.sv
